// File: hdl/pus_pkg.sv
`default_nettype none

package pus_pkg;

	localparam int unsigned IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_FRAME_TIME  = 3'd0;
	localparam logic [IDX_W-1:0] REG_GRAVITY_X   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GRAVITY_Y   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GRAVITY_Z   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRAG_RATE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SIZE_ACCEL  = 3'd5;
	localparam logic [IDX_W-1:0] REG_ANGLE_ACCEL = 3'd6;

	localparam logic [15:0]        FRAME_TIME_RESET = 16'd68;
	localparam logic signed [31:0] ONE_UNIT         = 32'sd4096;
	localparam logic [23:0]        DRAG_MAX         = 24'd4096;
	localparam logic [30:0]        AGE_MAX          = 31'h7fff_ffff;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		logic [15:0] frame_time;
		vec3_t       gravity;
		logic [19:0] drag_rate;
		logic [31:0] size_accel;
		logic [31:0] angle_accel;
	} cfg_t;

	typedef struct packed {
		logic [31:0] extent;
		logic [31:0] extent_rate;
		logic [31:0] angle;
		logic [31:0] angle_rate;
		logic [31:0] life_left;
		logic [30:0] age;
	} scalars_t;

	typedef struct packed {
		vec3_t    pos;
		vec3_t    vel;
		scalars_t sc;
	} particle_t;

	// products already cut to 32 bits (drag_ft to 24 bits); all but re and ra also shifted
	typedef struct packed {
		logic        live;
		particle_t   p;
		vec3_t       mv;
		vec3_t       gv;
		logic [31:0] ge;
		logic [31:0] ga;
		logic [31:0] re;
		logic [31:0] ra;
		logic [31:0] life_sub;
		logic [30:0] age_sum;
		logic [23:0] drag_ft;
	} s1_t;

	typedef struct packed {
		logic        live;
		vec3_t       pos;
		vec3_t       vel;
		vec3_t       gv;
		logic [12:0] te;
		scalars_t    sc;
	} s2_t;

	typedef struct packed {
		logic     live;
		vec3_t    pos;
		vec3_t    vel;
		vec3_t    gv;
		vec3_t    dv;
		scalars_t sc;
	} s3_t;

endpackage

`default_nettype wire

// File: hdl/pus_cfg_regs.sv
`default_nettype none

module pus_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [pus_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [31:0]               cfg_data,
	output pus_pkg::cfg_t                  cfg
);

	pus_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_time  <= pus_pkg::FRAME_TIME_RESET;
			cfg_q.gravity     <= '0;
			cfg_q.drag_rate   <= '0;
			cfg_q.size_accel  <= '0;
			cfg_q.angle_accel <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pus_pkg::REG_FRAME_TIME:  cfg_q.frame_time  <= cfg_data[15:0];
				pus_pkg::REG_GRAVITY_X:   cfg_q.gravity[0]  <= cfg_data;
				pus_pkg::REG_GRAVITY_Y:   cfg_q.gravity[1]  <= cfg_data;
				pus_pkg::REG_GRAVITY_Z:   cfg_q.gravity[2]  <= cfg_data;
				pus_pkg::REG_DRAG_RATE:   cfg_q.drag_rate   <= cfg_data[19:0];
				pus_pkg::REG_SIZE_ACCEL:  cfg_q.size_accel  <= cfg_data;
				pus_pkg::REG_ANGLE_ACCEL: cfg_q.angle_accel <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/pus_prod_stage.sv
`default_nettype none

module pus_prod_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pus_pkg::cfg_t      cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pus_pkg::particle_t in_p,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pus_pkg::s1_t            out_s
);

	logic                valid_s1;
	pus_pkg::s1_t        st_s1;
	pus_pkg::s1_t        nxt;
	logic signed [16:0]  ft_s;
	logic signed [14:0]  ft4_s;
	logic signed [44:0]  ge_p;
	logic signed [44:0]  ga_p;
	logic signed [48:0]  re_p;
	logic signed [48:0]  ra_p;
	logic [35:0]         drag_p;
	logic [31:0]         age_p;

	assign ft_s  = {1'b0, cfg.frame_time};
	assign ft4_s = {1'b0, cfg.frame_time[15:2]};

	assign ge_p   = $signed(in_p.sc.extent_rate[31:4]) * ft_s;
	assign ga_p   = $signed(in_p.sc.angle_rate[31:4]) * ft_s;
	assign re_p   = $signed(cfg.size_accel) * ft_s;
	assign ra_p   = $signed(cfg.angle_accel) * ft_s;
	assign drag_p = cfg.drag_rate * cfg.frame_time;
	assign age_p  = {1'b0, in_p.sc.age} + {16'd0, cfg.frame_time};

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [46:0] mv_p;
		logic signed [44:0] gv_p;
		assign mv_p       = $signed(in_p.vel[i][31:2]) * ft_s;
		assign gv_p       = $signed(cfg.gravity[i][31:2]) * ft4_s;
		assign nxt.mv[i]  = mv_p[41:10];
		assign nxt.gv[i]  = gv_p[43:12];
	end

	assign nxt.live     = $signed(in_p.sc.life_left) > 32'sd0;
	assign nxt.p        = in_p;
	assign nxt.ge       = ge_p[39:8];
	assign nxt.ga       = ga_p[39:8];
	assign nxt.re       = re_p[31:0];
	assign nxt.ra       = ra_p[31:0];
	assign nxt.life_sub = in_p.sc.life_left - {16'd0, cfg.frame_time};
	assign nxt.age_sum  = age_p[31] ? pus_pkg::AGE_MAX : age_p[30:0];
	assign nxt.drag_ft  = drag_p[35:12];

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_s     = st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pus_sum_stage.sv
`default_nettype none

module pus_sum_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pus_pkg::s1_t  in_s,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pus_pkg::s2_t       out_s
);

	logic          valid_s2;
	pus_pkg::s2_t  st_s2;
	pus_pkg::s2_t  nxt;
	logic [31:0]   ext_n;
	logic          shrunk;

	assign ext_n  = in_s.p.sc.extent + in_s.ge;
	assign shrunk = $signed(ext_n) < pus_pkg::ONE_UNIT;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign nxt.pos[i] = in_s.live ? in_s.p.pos[i] + in_s.mv[i] : in_s.p.pos[i];
	end

	assign nxt.live = in_s.live;
	assign nxt.vel  = in_s.p.vel;
	assign nxt.gv   = in_s.gv;
	// drag factor saturates at one unit
	assign nxt.te   = (in_s.drag_ft > pus_pkg::DRAG_MAX) ? pus_pkg::DRAG_MAX[12:0]
	                                                     : in_s.drag_ft[12:0];

	always_comb begin
		nxt.sc = in_s.p.sc;
		if (in_s.live) begin
			nxt.sc.extent      = ext_n;
			nxt.sc.extent_rate = in_s.p.sc.extent_rate + in_s.re;
			nxt.sc.angle       = in_s.p.sc.angle + in_s.ga;
			nxt.sc.angle_rate  = in_s.p.sc.angle_rate + in_s.ra;
			nxt.sc.life_left   = shrunk ? 32'd0 : in_s.life_sub;
			nxt.sc.age         = in_s.age_sum;
		end
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_s     = st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pus_drag_stage.sv
`default_nettype none

module pus_drag_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pus_pkg::s2_t  in_s,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pus_pkg::particle_t out_p
);

	logic               valid_s3;
	logic               valid_s4;
	logic               ready_s4;
	pus_pkg::s3_t       st_s3;
	pus_pkg::s3_t       nxt3;
	pus_pkg::particle_t st_s4;
	pus_pkg::particle_t nxt4;
	logic signed [13:0] te_s;

	assign te_s = {1'b0, in_s.te};

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [43:0] dv_p;
		assign dv_p        = $signed(in_s.vel[i][31:2]) * te_s;
		assign nxt3.dv[i]  = dv_p[41:10];
		// drag, then gravity; both wrap
		assign nxt4.vel[i] = st_s3.live ? st_s3.vel[i] - st_s3.dv[i] + st_s3.gv[i]
		                                : st_s3.vel[i];
	end

	assign nxt3.live = in_s.live;
	assign nxt3.pos  = in_s.pos;
	assign nxt3.vel  = in_s.vel;
	assign nxt3.gv   = in_s.gv;
	assign nxt3.sc   = in_s.sc;

	assign nxt4.pos  = st_s3.pos;
	assign nxt4.sc   = st_s3.sc;

	assign ready_s4  = !valid_s4 || out_ready;
	assign in_ready  = !valid_s3 || ready_s4;
	assign out_valid = valid_s4;
	assign out_p     = st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_s3 <= nxt3;
		end
		if (valid_s3 && ready_s4) begin
			st_s4 <= nxt4;
		end
	end

endmodule

`default_nettype wire

// File: hdl/particle_update_step.sv
// Particle update: one frame of Euler integration per particle word.
// Input channel: in_valid/in_stall with the twelve particle fields; a word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with the twelve new_ fields; the
// receiver holds out_stall high to keep the word in place.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no particle is in flight.
// Throughput: one particle per cycle, sustained while out_stall is low.
// Pipeline: a taken word passes through four register stages in order: the
// rate/product multipliers, the sums, the drag multipliers and the output
// register.
// Stall: out_stall freezes the run of full stages next to the output; in_stall
// rises only once every stage holds a word. Nothing is lost or duplicated.
// Reset (arst_n low): the pipeline empties and the registers return to
// frame_time 68, everything else 0.
`default_nettype none

module particle_update_step (
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [pus_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [31:0]               cfg_data,

	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [31:0]        pos_x,
	input  wire logic signed [31:0]        pos_y,
	input  wire logic signed [31:0]        pos_z,
	input  wire logic signed [31:0]        vel_x,
	input  wire logic signed [31:0]        vel_y,
	input  wire logic signed [31:0]        vel_z,
	input  wire logic signed [31:0]        extent,
	input  wire logic signed [31:0]        extent_rate,
	input  wire logic signed [31:0]        angle,
	input  wire logic signed [31:0]        angle_rate,
	input  wire logic signed [31:0]        life_left,
	input  wire logic [30:0]               age,

	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [31:0]             new_pos_x,
	output logic signed [31:0]             new_pos_y,
	output logic signed [31:0]             new_pos_z,
	output logic signed [31:0]             new_vel_x,
	output logic signed [31:0]             new_vel_y,
	output logic signed [31:0]             new_vel_z,
	output logic signed [31:0]             new_extent,
	output logic signed [31:0]             new_extent_rate,
	output logic signed [31:0]             new_angle,
	output logic signed [31:0]             new_angle_rate,
	output logic signed [31:0]             new_life_left,
	output logic [30:0]                    new_age
);

	pus_pkg::cfg_t      cfg;
	pus_pkg::particle_t in_p;
	pus_pkg::particle_t out_p;
	pus_pkg::s1_t       s1;
	pus_pkg::s2_t       s2;
	logic               in_ready;
	logic               v1;
	logic               r1;
	logic               v2;
	logic               r2;

	assign in_p.pos[0]        = pos_x;
	assign in_p.pos[1]        = pos_y;
	assign in_p.pos[2]        = pos_z;
	assign in_p.vel[0]        = vel_x;
	assign in_p.vel[1]        = vel_y;
	assign in_p.vel[2]        = vel_z;
	assign in_p.sc.extent      = extent;
	assign in_p.sc.extent_rate = extent_rate;
	assign in_p.sc.angle       = angle;
	assign in_p.sc.angle_rate  = angle_rate;
	assign in_p.sc.life_left   = life_left;
	assign in_p.sc.age         = age;

	assign in_stall = !in_ready;

	pus_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pus_prod_stage u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_p      (in_p),
		.out_valid (v1),
		.out_ready (r1),
		.out_s     (s1)
	);

	pus_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_s      (s1),
		.out_valid (v2),
		.out_ready (r2),
		.out_s     (s2)
	);

	pus_drag_stage u_drag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_s      (s2),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_p     (out_p)
	);

	assign new_pos_x       = out_p.pos[0];
	assign new_pos_y       = out_p.pos[1];
	assign new_pos_z       = out_p.pos[2];
	assign new_vel_x       = out_p.vel[0];
	assign new_vel_y       = out_p.vel[1];
	assign new_vel_z       = out_p.vel[2];
	assign new_extent      = out_p.sc.extent;
	assign new_extent_rate = out_p.sc.extent_rate;
	assign new_angle       = out_p.sc.angle;
	assign new_angle_rate  = out_p.sc.angle_rate;
	assign new_life_left   = out_p.sc.life_left;
	assign new_age         = out_p.sc.age;

endmodule

`default_nettype wire

// File: hdl/pus_checker.sv
`default_nettype none

module pus_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] new_extent,
	input wire logic signed [31:0] new_life_left
);

	// held output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// a taken word has reached the output, or is still held there, when out_valid is checked
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##4 out_valid)
		else $error("accepted word did not reach the output");

	// with the receiver free, the pipeline never backs up
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// a shrunk live particle dies; a dead one keeps its non-positive life
	a_shrunk_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (new_extent < 32'sd4096) |-> (new_life_left <= 32'sd0))
		else $error("small particle still alive");

endmodule

bind particle_update_step pus_checker u_pus_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.new_extent    (new_extent),
	.new_life_left (new_life_left)
);

`default_nettype wire
